>>> rtl/core/rsc_pkg.sv
// Package for the range scan to Cartesian converter.
// Holds widths, register indexes, CORDIC constants and the item types.
package rsc_pkg;

  localparam int MaxColumns   = 4096;
  localparam int MaxRows      = 256;
  localparam int CordicStages = 16;
  localparam int NumIter      = (CordicStages < 24) ? CordicStages : 24;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrW    = 2;

  localparam int CordicW = 44;  // holds 2^24 * 1.65^2 * 2^16 with margin
  localparam int StageW  = 5;

  localparam logic [29:0] Kinv2Q30 = 30'd395948877;
  localparam logic signed [24:0] OutMax = 25'sd16777215;
  localparam logic signed [24:0] OutMin = -25'sd16777216;

  typedef enum logic [2:0] {
    REG_AZ_START  = 3'd0,
    REG_AZ_STEP   = 3'd1,
    REG_EL_START  = 3'd2,
    REG_EL_STEP   = 3'd3,
    REG_ROW_LEN   = 3'd4,
    REG_ROW_COUNT = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ELEV = 2'd1,
    ST_AZIM = 2'd2,
    ST_DONE = 2'd3
  } back_state_e;

  // Classified item from the front part.
  typedef struct packed {
    logic [23:0] depth;
    logic        point_valid;
    logic [15:0] intensity;
    logic [15:0] azimuth;
    logic [15:0] elevation;
    logic [7:0]  ring;
    logic        frame_dense;
    logic        frame_end;
  } work_t;

  function automatic logic [31:0] atan_entry(input logic [StageW-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/range_scan_to_cartesian.sv
// Range scan to Cartesian converter, top level.
// Depends on rsc_pkg, rsc_front, rsc_queue, rsc_back.
//
// Usage: range samples enter on the in channel (valid/ready) in row-major
// scan order. Each gives one point on the out channel (valid/ready) with
// x, y, z in 1/256 m, intensity, ring (row) and frame flags.
// Config registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while
// the block is idle; any write to a known register restarts the frame.
// The front part tags each sample with its angles and flags combinationally and
// pushes it into a four-entry queue. The back part runs one shared CORDIC
// unit, 16 iterations for elevation then 16 for azimuth, and takes a new item
// only after the last one's result is loaded into the output register, so
// that CORDIC unit sets the throughput.
// Reset clears counters, angles to zero, dense flag to one, queue empty.
// When the receiver stalls the result waits in the output register, the
// back part finishes its next item and waits, and the queue fills before
// in_ready_o drops.
module range_scan_to_cartesian import rsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] depth_i,
  input  logic        depth_invalid_i,
  input  logic [15:0] intensity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [24:0] x_coord_o,
  output logic [24:0] y_coord_o,
  output logic [24:0] z_coord_o,
  output logic [15:0] intensity_out_o,
  output logic [7:0]  ring_o,
  output logic        point_valid_o,
  output logic        frame_dense_o,
  output logic        frame_end_o
);

  work_t w_in, w_out;
  logic  push, full, pop, empty;

  rsc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .depth_i, .depth_invalid_i, .intensity_i,
    .push_o(push), .work_o(w_in), .full_i(full)
  );

  rsc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(w_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(w_out)
  );

  rsc_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .work_i(w_out), .pop_o(pop),
    .out_valid_o, .out_ready_i, .x_coord_o, .y_coord_o, .z_coord_o,
    .intensity_out_o, .ring_o, .point_valid_o, .frame_dense_o, .frame_end_o
  );

endmodule

>>> rtl/core/rsc_front.sv
// Front part: scan counters, angle tracking, dense flag and config registers.
// Depends on rsc_pkg.
module rsc_front import rsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] depth_i,
  input  logic        depth_invalid_i,
  input  logic [15:0] intensity_i,
  output logic        push_o,
  output work_t       work_o,
  input  logic        full_i
);

  logic [15:0] az_start_q, az_step_q, el_start_q, el_step_q;
  logic [12:0] row_len_q;
  logic [8:0]  row_cnt_q;
  logic [11:0] col_q;
  logic [7:0]  row_q;
  logic [15:0] az_q, el_q;
  logic        dense_q;
  logic [12:0] len_c;
  logic [8:0]  rows_c;
  logic        last_col, last_row, dense_now, fire, cfg_hit;

  // Clamp dimensions to 1..max
  always_comb begin
    len_c  = (row_len_q == 13'd0) ? 13'd1 :
             (row_len_q > 13'(MaxColumns)) ? 13'(MaxColumns) : row_len_q;
    rows_c = (row_cnt_q == 9'd0) ? 9'd1 :
             (row_cnt_q > 9'(MaxRows)) ? 9'(MaxRows) : row_cnt_q;
    last_col  = ({1'b0, col_q} + 13'd1) >= len_c;
    last_row  = ({1'b0, row_q} + 9'd1) >= rows_c;
    dense_now = dense_q & ~depth_invalid_i;
    fire      = in_valid_i & ~full_i;
    cfg_hit   = cfg_we_i & (cfg_idx_i <= REG_ROW_COUNT);
  end

  assign in_ready_o = ~full_i;
  assign push_o     = fire;

  always_comb begin
    work_o.depth       = depth_i;
    work_o.point_valid = ~depth_invalid_i;
    work_o.intensity   = intensity_i;
    work_o.azimuth     = az_q;
    work_o.elevation   = el_q;
    work_o.ring        = row_q;
    work_o.frame_dense = dense_now;
    work_o.frame_end   = last_col & last_row;
  end

  // Hold config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_start_q <= '0; az_step_q <= '0; el_start_q <= '0; el_step_q <= '0;
      row_len_q <= 13'd1; row_cnt_q <= 9'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AZ_START:  az_start_q <= cfg_data_i;
        REG_AZ_STEP:   az_step_q  <= cfg_data_i;
        REG_EL_START:  el_start_q <= cfg_data_i;
        REG_EL_STEP:   el_step_q  <= cfg_data_i;
        REG_ROW_LEN:   row_len_q  <= cfg_data_i[12:0];
        REG_ROW_COUNT: row_cnt_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Advance scan position; restart on a config write to a known register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; az_q <= '0; el_q <= '0; dense_q <= 1'b1;
    end else if (cfg_hit) begin
      col_q <= '0; row_q <= '0; dense_q <= 1'b1;
      az_q <= (cfg_idx_i == REG_AZ_START) ? cfg_data_i : az_start_q;
      el_q <= (cfg_idx_i == REG_EL_START) ? cfg_data_i : el_start_q;
    end else if (fire) begin
      dense_q <= dense_now;
      if (last_col) begin
        col_q <= '0;
        az_q  <= az_start_q;
        if (last_row) begin
          row_q <= '0; el_q <= el_start_q; dense_q <= 1'b1;
        end else begin
          row_q <= row_q + 8'd1;
          el_q  <= el_q + el_step_q;
        end
      end else begin
        col_q <= col_q + 12'd1;
        az_q  <= az_q + az_step_q;
      end
    end
  end

endmodule

>>> rtl/core/rsc_queue.sv
// Short FIFO of classified items between the front and back parts.
// Depends on rsc_pkg.
module rsc_queue import rsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output work_t data_o
);

  work_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Track pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push_i) - (QueuePtrW+1)'(pop_i);
    end
  end

endmodule

>>> rtl/core/rsc_back.sv
// Back part: iterative CORDIC (elevation then azimuth) and output register.
// Depends on rsc_pkg.
module rsc_back import rsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  work_t        work_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [24:0]  x_coord_o,
  output logic [24:0]  y_coord_o,
  output logic [24:0]  z_coord_o,
  output logic [15:0]  intensity_out_o,
  output logic [7:0]   ring_o,
  output logic         point_valid_o,
  output logic         frame_dense_o,
  output logic         frame_end_o
);

  back_state_e state_q, state_d;
  work_t       item_q;
  logic signed [CordicW-1:0] x_q, y_q, zc_q;
  logic signed [32:0] ang_q;
  logic [StageW-1:0]  it_q;
  logic [53:0]        prod;
  logic signed [CordicW-1:0] v_start, dx, dy, x_n, y_n, pre_x;
  logic signed [32:0] a_n, ang_in, atan_s;
  logic [15:0]        ang16;
  logic               flip, last_it, take;
  logic [24:0] xo_q, yo_q, zo_q;
  logic        ov_q;

  // Start vector: round(depth * Kinv2 / 2^14)
  assign prod    = 54'(work_i.depth) * 54'(Kinv2Q30) + 54'd8192;
  assign v_start = CordicW'(prod >> 14);
  assign last_it = (it_q == StageW'(NumIter - 1));
  assign take    = (state_q == ST_IDLE) & ~empty_i;
  assign pop_o   = take;

  // Fold angle into +-90 degrees
  always_comb begin
    ang16  = (state_q == ST_IDLE) ? work_i.elevation : item_q.azimuth;
    pre_x  = (state_q == ST_IDLE) ? v_start : x_q;
    ang_in = {ang16[15], ang16, 16'd0};
    flip   = (ang_in > 33'sd1073741824) | (ang_in < -33'sd1073741824);
  end

  // One CORDIC iteration
  always_comb begin
    dx     = y_q >>> it_q;
    dy     = x_q >>> it_q;
    atan_s = $signed({1'b0, atan_entry(it_q)});
    if (!ang_q[32]) begin
      x_n = x_q - dx; y_n = y_q + dy; a_n = ang_q - atan_s;
    end else begin
      x_n = x_q + dx; y_n = y_q - dy; a_n = ang_q + atan_s;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_ELEV;
      ST_ELEV: if (last_it) state_d = ST_AZIM;
      ST_AZIM: if (last_it) state_d = ST_DONE;
      ST_DONE: if (!ov_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  function automatic logic [24:0] fin(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] r;
    r = (v + CordicW'(32768)) >>> 16;
    if (r > CordicW'(OutMax)) return OutMax;
    if (r < CordicW'(OutMin)) return OutMin;
    return r[24:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Run datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        item_q <= work_i;
        x_q    <= flip ? -pre_x : pre_x;
        y_q    <= '0;
        ang_q  <= flip ? (ang_in[32] ? ang_in + 33'sd2147483648
                                     : ang_in - 33'sd2147483648) : ang_in;
        it_q   <= '0;
      end
      ST_ELEV: begin
        if (last_it) begin
          zc_q  <= y_n;
          x_q   <= flip ? -x_n : x_n;
          y_q   <= '0;
          ang_q <= flip ? (ang_in[32] ? ang_in + 33'sd2147483648
                                      : ang_in - 33'sd2147483648) : ang_in;
          it_q  <= '0;
        end else begin
          x_q <= x_n; y_q <= y_n; ang_q <= a_n; it_q <= it_q + 1'b1;
        end
      end
      ST_AZIM: begin
        x_q <= x_n; y_q <= y_n; ang_q <= a_n; it_q <= it_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: load when done and free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (state_q == ST_DONE && (!ov_q || out_ready_i)) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!ov_q || out_ready_i)) begin
      xo_q <= item_q.point_valid ? fin(x_q) : '0;
      yo_q <= item_q.point_valid ? fin(y_q) : '0;
      zo_q <= item_q.point_valid ? fin(zc_q) : '0;
      intensity_out_o <= item_q.intensity;
      ring_o          <= item_q.ring;
      point_valid_o   <= item_q.point_valid;
      frame_dense_o   <= item_q.frame_dense;
      frame_end_o     <= item_q.frame_end;
    end
  end

  assign out_valid_o = ov_q;
  assign x_coord_o   = xo_q;
  assign y_coord_o   = yo_q;
  assign z_coord_o   = zo_q;

endmodule

>>> tb/sv/tb_range_scan_to_cartesian.sv
// Testbench for range_scan_to_cartesian: random and directed range samples,
// a CORDIC point predictor in the bench, and field-by-field checking.
// Depends on rsc_pkg and the range_scan_to_cartesian RTL.
module tb_range_scan_to_cartesian;
  import rsc_pkg::*;

  typedef struct packed {
    logic [23:0] depth;
    logic        invalid;
    logic [15:0] intensity;
  } sample_t;

  typedef struct packed {
    logic [24:0] x;
    logic [24:0] y;
    logic [24:0] z;
    logic [15:0] intensity;
    logic [7:0]  ring;
    logic        point_valid;
    logic        dense;
    logic        frame_end;
  } point_t;

  localparam int SampleGapMax = 8;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [23:0] depth_i;
  logic        depth_invalid_i;
  logic [15:0] intensity_i;
  logic        out_valid_o, out_ready_i;
  logic [24:0] x_coord_o, y_coord_o, z_coord_o;
  logic [15:0] intensity_out_o;
  logic [7:0]  ring_o;
  logic        point_valid_o, frame_dense_o, frame_end_o;

  range_scan_to_cartesian u_top (.*);

  // Scan geometry copy and scan position
  logic [15:0] az_start, az_step, el_start, el_step;
  logic [12:0] row_len;
  logic [8:0]  row_cnt;
  int unsigned col_pos, row_pos;
  logic [15:0] cur_az, cur_el;
  logic        dense_q;

  sample_t pending_samples[$];
  point_t  expected_points[$];
  int      error_count;
  int      points_seen;
  int      invalid_seen;
  int      frames_seen;
  bit      in_taken;
  bit      out_taken;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Timeout at %0t", $time);
    $display("Some tests failed");
    $finish;
  end

  function automatic longint unsigned atan_val(int i);
    logic [31:0] t [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  // Rotate (x0, 0) by a binary angle; >>> on signed longint floors
  function automatic void cordic_rotate(input longint x0, input logic [15:0] ang,
                                        output longint xo, output longint yo);
    longint x, y, z, dx, dy;
    x = x0;
    y = 0;
    z = longint'($signed({ang, 16'h0}));
    if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
      z = (z > 0) ? z - 64'sd2147483648 : z + 64'sd2147483648;
      x = -x;
    end
    for (int i = 0; i < CordicStages && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_val(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_val(i));
      end
    end
    xo = x;
    yo = y;
  endfunction

  function automatic logic [24:0] round_sat(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16777215) r = 16777215;
    if (r < -16777216) r = -16777216;
    return r[24:0];
  endfunction

  function automatic void restart_scan();
    col_pos = 0;
    row_pos = 0;
    cur_az  = az_start;
    cur_el  = el_start;
    dense_q = 1'b1;
  endfunction

  // Append one sample to the pending list
  function automatic void queue_sample(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  // Compute the point for one accepted sample and advance the scan position
  function automatic point_t predict_point(sample_t s);
    point_t p;
    int unsigned len, rows;
    bit last_col, last_row;
    longint v, r, z, x, y;
    len  = (row_len == 0) ? 1 : ((row_len > MaxColumns) ? MaxColumns : row_len);
    rows = (row_cnt == 0) ? 1 : ((row_cnt > MaxRows) ? MaxRows : row_cnt);
    last_col = col_pos + 1 >= len;
    last_row = row_pos + 1 >= rows;
    if (!s.invalid) begin
      v = longint'((longint'(s.depth) * 64'd395948877 + 64'd8192) >> 14);
      cordic_rotate(v, cur_el, r, z);
      cordic_rotate(r, cur_az, x, y);
      p.x = round_sat(x);
      p.y = round_sat(y);
      p.z = round_sat(z);
    end else begin
      p.x = '0;
      p.y = '0;
      p.z = '0;
      dense_q = 1'b0;
    end
    p.intensity   = s.intensity;
    p.ring        = row_pos[7:0];
    p.point_valid = !s.invalid;
    p.dense       = dense_q;
    p.frame_end   = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      cur_az  = az_start;
      if (last_row) begin
        row_pos = 0;
        cur_el  = el_start;
        dense_q = 1'b1;
      end else begin
        row_pos++;
        cur_el = cur_el + el_step;
      end
    end else begin
      col_pos++;
      cur_az = cur_az + az_step;
    end
    return p;
  endfunction

  // Driver: hold valid until accepted, random gap between items
  int unsigned send_gap;
  initial begin
    in_valid_i = 1'b0;
    depth_i = '0;
    depth_invalid_i = 1'b0;
    intensity_i = '0;
    send_gap = 0;
    in_taken = 1'b0;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_points.insert(expected_points.size(),
                             predict_point({depth_i, depth_invalid_i, intensity_i}));
      if (depth_invalid_i) invalid_seen++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold
      end else begin
        in_taken = 1'b0;
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_samples.size() != 0) begin
          sample_t s;
          s = pending_samples.pop_front();
          in_valid_i      <= 1'b1;
          depth_i         <= s.depth;
          depth_invalid_i <= s.invalid;
          intensity_i     <= s.intensity;
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, SampleGapMax);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls, compare each point with the oldest prediction
  int unsigned stall_left;
  bit stall_free;
  initial begin
    out_ready_i = 1'b0;
    stall_left = 0;
    stall_free = 1'b0;
    out_taken = 1'b0;
  end

  always @(negedge clk_i) begin
    int unsigned w;
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_taken && !stall_free) begin
      w = $urandom_range(0, SampleGapMax);
      out_ready_i <= (w == 0);
      stall_left <= (w == 0) ? 0 : w - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
    out_taken = 1'b0;
  end

  always @(posedge clk_i) begin
    point_t got, want;
    if (out_valid_o && out_ready_i) begin
      out_taken = 1'b1;
      got = {x_coord_o, y_coord_o, z_coord_o, intensity_out_o, ring_o,
             point_valid_o, frame_dense_o, frame_end_o};
      points_seen++;
      if (frame_end_o) frames_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point %h", $time, got);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x)
          $display("%0t: x exp %h got %h", $time, want.x, got.x);
        if (got.y !== want.y)
          $display("%0t: y exp %h got %h", $time, want.y, got.y);
        if (got.z !== want.z)
          $display("%0t: z exp %h got %h", $time, want.z, got.z);
        if (got.intensity !== want.intensity)
          $display("%0t: intensity exp %h got %h", $time, want.intensity, got.intensity);
        if (got.ring !== want.ring)
          $display("%0t: ring exp %0d got %0d", $time, want.ring, got.ring);
        if (got.point_valid !== want.point_valid)
          $display("%0t: point_valid exp %b got %b", $time, want.point_valid,
                   got.point_valid);
        if (got.dense !== want.dense)
          $display("%0t: frame_dense exp %b got %b", $time, want.dense, got.dense);
        if (got.frame_end !== want.frame_end)
          $display("%0t: frame_end exp %b got %b", $time, want.frame_end, got.frame_end);
        if (got !== want) error_count++;
      end
    end
  end

  // Wait until the block has drained every queued and expected item
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || send_gap != 0 ||
           expected_points.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_AZ_START:  az_start = val;
      REG_AZ_STEP:   az_step  = val;
      REG_EL_START:  el_start = val;
      REG_EL_STEP:   el_step  = val;
      REG_ROW_LEN:   row_len  = val[12:0];
      REG_ROW_COUNT: row_cnt  = val[8:0];
      default: ;
    endcase
    if (idx <= REG_ROW_COUNT) restart_scan();
  endtask

  // Program a full geometry
  task automatic set_scan(logic [15:0] azs, logic [15:0] azd, logic [15:0] els,
                          logic [15:0] eld, logic [15:0] len, logic [15:0] rows);
    write_reg(REG_AZ_START, azs);
    write_reg(REG_AZ_STEP, azd);
    write_reg(REG_EL_START, els);
    write_reg(REG_EL_STEP, eld);
    write_reg(REG_ROW_LEN, len);
    write_reg(REG_ROW_COUNT, rows);
  endtask

  function automatic sample_t rand_sample(int invalid_pct);
    sample_t s;
    case ($urandom_range(0, 5))
      0: s.depth = 24'hFFFFFF - 24'($urandom_range(0, 15));
      1: s.depth = 24'($urandom_range(0, 255));
      default: s.depth = 24'($urandom);
    endcase
    s.invalid   = ($urandom_range(0, 99) < invalid_pct);
    s.intensity = 16'($urandom);
    return s;
  endfunction

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_AZ_START;
    cfg_data_i = '0;
    error_count = 0;
    points_seen = 0;
    invalid_seen = 0;
    frames_seen = 0;
    az_start = '0; az_step = '0; el_start = '0; el_step = '0;
    row_len = 13'd1; row_cnt = 9'd1;
    restart_scan();
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset geometry, depth and intensity extremes, invalid samples
    queue_sample('{24'h0, 1'b0, 16'h0});
    queue_sample('{24'hFFFFFF, 1'b0, 16'hFFFF});
    queue_sample('{24'hFFFFFF, 1'b1, 16'h1234});
    queue_sample('{24'h000100, 1'b0, 16'h8000});
    drain();
    // Angles near and beyond a quarter turn, negative steps, 2x3 frame
    set_scan(16'h4000, 16'h4001, 16'h8000, 16'hC000, 16'd2, 16'd3);
    for (int i = 0; i < 6; i++)
      queue_sample('{24'hFFFFFF, (i == 2), 16'(i)});
    drain();
    // Zero length and count act as one; out-of-range index is ignored
    set_scan(16'h7FFF, 16'h8000, 16'h3FFF, 16'h0001, 16'd0, 16'd0);
    write_reg(reg_idx_e'(3'd7), 16'hFFFF);
    for (int i = 0; i < 3; i++) queue_sample(rand_sample(30));
    drain();
    // Oversized row length and row count saturate to the maximum
    set_scan(16'h0000, 16'h0100, 16'hC001, 16'h0101, 16'h1FFF, 16'h01FF);
    for (int i = 0; i < 8; i++) queue_sample(rand_sample(10));
    drain();

    // Random phases over several geometries
    for (int ph = 0; ph < 12; ph++) begin
      int unsigned len, rows, n;
      len  = (ph % 4 == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
      rows = (ph == 5) ? 256 : $urandom_range(1, 8);
      if (ph == 5) len = 1;
      set_scan(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'(len), 16'(rows));
      n = (ph == 5) ? 300 : 80;
      stall_free = (ph == 7);
      for (int i = 0; i < n; i++)
        queue_sample(rand_sample((ph % 3 == 0) ? 2 : 15));
      // In phase 3, drop the unsent samples mid-phase, wait until all points have returned, then send 40 more
      if (ph == 3) begin
        while (pending_samples.size() > 40) @(posedge clk_i);
        while (pending_samples.size() != 0) pending_samples.pop_back();
        drain();
        for (int i = 0; i < 40; i++) queue_sample(rand_sample(15));
      end
      drain();
    end
    stall_free = 0;

    $display("Covered %0d points, %0d invalid samples, %0d frame ends", points_seen,
             invalid_seen, frames_seen);
    $display("Geometries: reset, extremes, zero and oversized sizes, 12 random scans");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> range_scan_to_cartesian.f
rtl/core/rsc_pkg.sv
rtl/core/rsc_front.sv
rtl/core/rsc_queue.sv
rtl/core/rsc_back.sv
rtl/core/range_scan_to_cartesian.sv
tb/sv/tb_range_scan_to_cartesian.sv
